// File: rtl/xcfr_pkg.sv
// Shared types and constants for the XOR-checked frame receiver.
`timescale 1ns / 1ps

package xcfr_pkg;

    // Default number of 16-bit words that a frame payload may carry.
    localparam int MAX_WORDS_DEF = 8;

    // Byte that opens every frame.
    localparam logic [7:0] START_BYTE = 8'hAA;

    // Result status codes.
    localparam logic [1:0] ST_WORD  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_CSUM  = 2'd2;
    localparam logic [1:0] ST_ID    = 2'd3;

    // Receiver phases, including the two word emission steps.
    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_ID    = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_SUM   = 3'd4,
        PH_READ  = 3'd5,
        PH_SHOW  = 3'd6
    } phase_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_id;
        logic cap_len;
        logic cap_data;
        logic load_sum;
        logic rd_en;
        logic load_word;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_start;
        logic len_over;
        logic len_zero;
        logic data_done;
        logic emit_go;
        logic cnt_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: rtl/xor_checked_frame_receiver_unit.sv
// Top level of the XOR-checked frame receiver.
`timescale 1ns / 1ps

// The receiver takes one serial byte per transfer and hunts for the start
// byte 0xAA, then reads an id byte, a length byte, that many data bytes and
// a checksum byte, keeping a running XOR over id, length and data. A length
// above 2*MAX_WORDS drops the frame without any result. On the checksum byte
// a frame with a wrong checksum gives one result with status 2, a frame with
// a foreign id (own_id, written through own_id_we/own_id_wdata) gives status
// 3, and a good frame gives one result per big-endian 16-bit data word, or a
// single status 1 result when it holds fewer than two data bytes; the final
// result of each frame has last set. Bytes are taken at one per cycle while
// a frame is being received. After the checksum byte of a good frame with N
// words the input is stalled during their emission and any output stall, because
// each word takes one read of the single-port payload memory and one load of
// the output register. The checksum byte itself waits only while the output
// register holds an earlier result that has not yet been transferred. The
// payload memory holds MAX_WORDS entries of 16 bits and needs no clearing
// after reset, since only entries written in the current frame are read.

module xor_checked_frame_receiver_unit
#(
    parameter int MAX_WORDS = xcfr_pkg::MAX_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               own_id_we,
    input  logic [7:0]         own_id_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [2:0]         word_index,
    output logic signed [15:0] word_value,
    output logic               last
);

    // Commands and status that join the controller and the datapath.
    xcfr_pkg::dp_cmd_t  cmd;
    xcfr_pkg::dp_stat_t stat;

    // The controller sequences the frame phases and the word emission.
    xcfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the header, checksum, payload memory and the
    // output register that decouples the result side from the input side.
    xcfr_dp
    #(
        .MAX_WORDS (MAX_WORDS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .own_id_we    (own_id_we),
        .own_id_wdata (own_id_wdata),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .word_index   (word_index),
        .word_value   (word_value),
        .last         (last)
    );

endmodule

// File: rtl/xcfr_ctrl.sv
// Phase controller of the frame receiver: input flow control and sequencing.
`timescale 1ns / 1ps

module xcfr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  xcfr_pkg::dp_stat_t stat,
    output xcfr_pkg::dp_cmd_t  cmd
);

    xcfr_pkg::phase_t phase_reg;
    xcfr_pkg::phase_t phase_next;
    logic             in_acc;

    // Input is held off during word emission, and on the checksum byte
    // while the previous result still occupies the output register.
    always_comb
    begin
        case (phase_reg)
            xcfr_pkg::PH_READ: in_stall = 1'b1;
            xcfr_pkg::PH_SHOW: in_stall = 1'b1;
            xcfr_pkg::PH_SUM:  in_stall = ~stat.out_free;
            default:           in_stall = 1'b0;
        endcase
    end

    assign in_acc = in_valid & ~in_stall;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            xcfr_pkg::PH_START:
            begin
                if (in_acc && stat.is_start)
                begin
                    phase_next = xcfr_pkg::PH_ID;
                end
            end
            xcfr_pkg::PH_ID:
            begin
                if (in_acc)
                begin
                    phase_next = xcfr_pkg::PH_LEN;
                end
            end
            xcfr_pkg::PH_LEN:
            begin
                if (in_acc)
                begin
                    if (stat.len_over)
                    begin
                        phase_next = xcfr_pkg::PH_START;
                    end
                    else if (stat.len_zero)
                    begin
                        phase_next = xcfr_pkg::PH_SUM;
                    end
                    else
                    begin
                        phase_next = xcfr_pkg::PH_DATA;
                    end
                end
            end
            xcfr_pkg::PH_DATA:
            begin
                if (in_acc && stat.data_done)
                begin
                    phase_next = xcfr_pkg::PH_SUM;
                end
            end
            xcfr_pkg::PH_SUM:
            begin
                if (in_acc)
                begin
                    phase_next = stat.emit_go ? xcfr_pkg::PH_READ : xcfr_pkg::PH_START;
                end
            end
            xcfr_pkg::PH_READ:
            begin
                phase_next = xcfr_pkg::PH_SHOW;
            end
            xcfr_pkg::PH_SHOW:
            begin
                if (stat.out_free)
                begin
                    phase_next = stat.cnt_last ? xcfr_pkg::PH_START : xcfr_pkg::PH_READ;
                end
            end
            default:
            begin
                phase_next = xcfr_pkg::PH_START;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (phase_reg)
            xcfr_pkg::PH_ID:   cmd.cap_id    = in_acc;
            xcfr_pkg::PH_LEN:  cmd.cap_len   = in_acc;
            xcfr_pkg::PH_DATA: cmd.cap_data  = in_acc;
            xcfr_pkg::PH_SUM:  cmd.load_sum  = in_acc & ~stat.emit_go;
            xcfr_pkg::PH_READ: cmd.rd_en     = 1'b1;
            xcfr_pkg::PH_SHOW: cmd.load_word = stat.out_free;
            default:           cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= xcfr_pkg::PH_START;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

// File: rtl/xcfr_dp.sv
// Datapath of the frame receiver: header, checksum, payload buffer, output register.
`timescale 1ns / 1ps

module xcfr_dp
#(
    parameter int MAX_WORDS = xcfr_pkg::MAX_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               own_id_we,
    input  logic [7:0]         own_id_wdata,
    input  logic [7:0]         rx_byte,
    input  xcfr_pkg::dp_cmd_t  cmd,
    output xcfr_pkg::dp_stat_t stat,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [2:0]         word_index,
    output logic signed [15:0] word_value,
    output logic               last
);

    localparam int BUF_BYTES = 2 * MAX_WORDS;
    localparam int CW        = $clog2(BUF_BYTES + 1);
    localparam int WW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

    logic [7:0]         own_id_reg, own_id_next;
    logic [7:0]         frame_id_reg, frame_id_next;
    logic [CW-1:0]      frame_len_reg, frame_len_next;
    logic [CW-1:0]      byte_cnt_reg, byte_cnt_next;
    logic [7:0]         csum_reg, csum_next;
    logic [7:0]         hi_reg, hi_next;
    logic [WW-1:0]      word_cnt_reg, word_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         status_reg, status_next;
    logic [2:0]         index_reg, index_next;
    logic signed [15:0] value_reg, value_next;
    logic               last_reg, last_next;
    logic [15:0]        rdata_reg;
    logic [15:0]        payload_mem [MAX_WORDS];

    logic [CW:0]        cnt_inc;
    logic [CW-2:0]      words;
    logic [CW-2:0]      word_inc;
    logic               sum_ok;
    logic               id_ok;
    logic               mem_we;
    logic [1:0]         sum_code;

    assign cnt_inc  = {1'b0, byte_cnt_reg} + (CW + 1)'(1);
    assign words    = frame_len_reg[CW-1:1];
    assign word_inc = (CW - 1)'(word_cnt_reg) + (CW - 1)'(1);
    assign sum_ok   = (csum_reg == rx_byte);
    assign id_ok    = (frame_id_reg == own_id_reg);
    assign mem_we   = cmd.cap_data & byte_cnt_reg[0];

    always_comb
    begin
        if (!sum_ok)
        begin
            sum_code = xcfr_pkg::ST_CSUM;
        end
        else if (!id_ok)
        begin
            sum_code = xcfr_pkg::ST_ID;
        end
        else
        begin
            sum_code = xcfr_pkg::ST_EMPTY;
        end
    end

    always_comb
    begin
        stat.is_start  = (rx_byte == xcfr_pkg::START_BYTE);
        stat.len_over  = (rx_byte > 8'(BUF_BYTES));
        stat.len_zero  = (rx_byte == 8'd0);
        stat.data_done = (cnt_inc >= {1'b0, frame_len_reg});
        stat.emit_go   = sum_ok & id_ok & (words != '0);
        stat.cnt_last  = (word_inc == words);
        stat.out_free  = ~out_valid_reg | ~out_stall;
    end

    always_comb
    begin
        own_id_next    = own_id_we ? own_id_wdata : own_id_reg;
        frame_id_next  = cmd.cap_id ? rx_byte : frame_id_reg;
        frame_len_next = cmd.cap_len ? CW'(rx_byte) : frame_len_reg;
        byte_cnt_next  = byte_cnt_reg;
        csum_next      = csum_reg;
        hi_next        = hi_reg;
        word_cnt_next  = word_cnt_reg;
        if (cmd.cap_id)
        begin
            csum_next = rx_byte;
        end
        if (cmd.cap_len)
        begin
            csum_next     = csum_reg ^ rx_byte;
            byte_cnt_next = '0;
            word_cnt_next = '0;
        end
        if (cmd.cap_data)
        begin
            csum_next     = csum_reg ^ rx_byte;
            byte_cnt_next = cnt_inc[CW-1:0];
            if (!byte_cnt_reg[0])
            begin
                hi_next = rx_byte;
            end
        end
        if (cmd.load_word && !stat.cnt_last)
        begin
            word_cnt_next = WW'(word_inc);
        end

        out_valid_next = out_valid_reg & out_stall;
        status_next    = status_reg;
        index_next     = index_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        if (cmd.load_sum)
        begin
            out_valid_next = 1'b1;
            status_next    = sum_code;
            index_next     = 3'd0;
            value_next     = 16'sd0;
            last_next      = 1'b1;
        end
        else if (cmd.load_word)
        begin
            out_valid_next = 1'b1;
            status_next    = xcfr_pkg::ST_WORD;
            index_next     = 3'(word_cnt_reg);
            value_next     = $signed(rdata_reg);
            last_next      = stat.cnt_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg    <= 8'd0;
            frame_id_reg  <= 8'd0;
            frame_len_reg <= '0;
            byte_cnt_reg  <= '0;
            csum_reg      <= 8'd0;
            word_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            own_id_reg    <= own_id_next;
            frame_id_reg  <= frame_id_next;
            frame_len_reg <= frame_len_next;
            byte_cnt_reg  <= byte_cnt_next;
            csum_reg      <= csum_next;
            word_cnt_reg  <= word_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg     <= hi_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        value_reg  <= value_next;
        last_reg   <= last_next;
    end

    // Payload buffer: one word written per byte pair, one registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payload_mem[byte_cnt_reg[WW:1]] <= {hi_reg, rx_byte};
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= payload_mem[word_cnt_reg];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign word_index = index_reg;
    assign word_value = value_reg;
    assign last       = last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_sum || cmd.load_word) |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending transfer");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != xcfr_pkg::ST_WORD) |-> last_reg)
        else $error("status result not marked last");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != xcfr_pkg::ST_WORD)
            |-> (value_reg == 16'sd0 && index_reg == 3'd0))
        else $error("status result carries word data");

endmodule
